// ===== rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the set-associative cache tag controller.
// Geometry constants, the state machine type and the structs passed between the modules.
// No dependencies.
package sacl_pkg;

  localparam int unsigned SETS       = 64;
  localparam int unsigned WAYS       = 8;
  localparam int unsigned LINE_BYTES = 64;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned OFFSET_W = $clog2(LINE_BYTES);
  localparam int unsigned TAG_W    = ADDR_W - OFFSET_W;
  localparam int unsigned SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W   = WAY_W;
  localparam int unsigned OUT_WAY_W = 3;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  // APB register indexes
  localparam logic REG_REPLACEMENT = 1'b0;
  localparam logic REG_WRITE_BACK  = 1'b1;

  localparam logic REPL_LRU  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_e;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0]             dirty;
    logic [WAYS-1:0][RANK_W-1:0] rank;
  } meta_row_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
  } rd_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
    logic [WAY_W-1:0] way;
    logic [TAG_W-1:0] tag;
    logic             tag_en;
    meta_row_t        meta;
  } wr_t;

  typedef struct packed {
    logic replacement_mode;
    logic write_back_mode;
  } cfg_t;

endpackage

// ===== rtl/sacl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the access requests and the lookup results.
// Depends on sacl_pkg for the address and way widths.
interface sacl_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [sacl_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface sacl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [sacl_pkg::OUT_WAY_W-1:0] way;
  logic                           memory_read;
  logic                           memory_write;
  logic                           dirty_eviction;

  modport source (output valid, output hit, output way, output memory_read,
                  output memory_write, output dirty_eviction, input ready);
  modport sink   (input valid, input hit, input way, input memory_read,
                  input memory_write, input dirty_eviction, output ready);
endinterface

// ===== rtl/sacl_tag_ram.sv =====
`timescale 1ns / 1ps
// Tag memory: one row per set holding the tags of all ways, registered read.
// Depends on sacl_pkg. Contents are undefined until written.
module sacl_tag_ram (
  input  logic                clk_i,
  input  sacl_pkg::rd_t       rd_i,
  input  sacl_pkg::wr_t       wr_i,
  output sacl_pkg::tag_row_t  rdata_o
);

  sacl_pkg::tag_row_t mem [sacl_pkg::SETS];
  sacl_pkg::tag_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.tag_en) begin
      mem[wr_i.set][wr_i.way] <= wr_i.tag;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.set];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sacl_meta_ram.sv =====
`timescale 1ns / 1ps
// Line state memory: valid, dirty and age rank of every way, one row per set.
// Depends on sacl_pkg. A per-row written flag makes untouched rows read as all zero.
module sacl_meta_ram (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sacl_pkg::rd_t        rd_i,
  input  sacl_pkg::wr_t        wr_i,
  output sacl_pkg::meta_row_t  rdata_o
);

  sacl_pkg::meta_row_t       mem [sacl_pkg::SETS];
  sacl_pkg::meta_row_t       rdata_q;
  logic [sacl_pkg::SETS-1:0] row_init_q;
  logic                      init_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.set] <= wr_i.meta;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
      init_q     <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_init_q[wr_i.set] <= 1'b1;
      end
      if (rd_i.en) begin
        init_q <= row_init_q[rd_i.set];
      end
    end
  end

  assign rdata_o = init_q ? rdata_q : '0;

endmodule

// ===== rtl/sacl_ctrl.sv =====
`timescale 1ns / 1ps
// Lookup controller: reads a set, compares tags, picks the victim, writes the set back
// and holds the result in an output register. Depends on sacl_pkg and sacl_if.
module sacl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sacl_req_if.sink             req_i,
  sacl_rsp_if.source           rsp_o,
  input  sacl_pkg::cfg_t       cfg_i,
  input  sacl_pkg::tag_row_t   tag_row_i,
  input  sacl_pkg::meta_row_t  meta_row_i,
  output sacl_pkg::rd_t        rd_o,
  output sacl_pkg::wr_t        wr_o
);

  sacl_pkg::state_e state_q, state_d;

  logic                        req_type_q;
  logic [sacl_pkg::TAG_W-1:0]  tag_q;

  logic                            rsp_valid_q, rsp_valid_d;
  logic                            hit_q;
  logic [sacl_pkg::OUT_WAY_W-1:0]  way_q;
  logic                            mread_q;
  logic                            mwrite_q;
  logic                            dev_q;

  logic                            req_xfer;
  logic                            done;

  logic [sacl_pkg::WAYS-1:0]       match;
  logic [sacl_pkg::WAYS-1:0]       oldest;
  logic                            hit;
  logic                            full;
  logic [sacl_pkg::WAY_W-1:0]      hit_way;
  logic [sacl_pkg::WAY_W-1:0]      empty_way;
  logic [sacl_pkg::WAY_W-1:0]      old_way;
  logic [sacl_pkg::WAY_W-1:0]      sel_way;
  logic                            dev;
  logic                            mwrite;
  sacl_pkg::meta_row_t             meta_new;

  // State machine: accept in idle, resolve the lookup once the set is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    done        = 1'b0;
    unique case (state_q)
      sacl_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = sacl_pkg::S_LOOK;
        end
      end
      sacl_pkg::S_LOOK: begin
        // hold the lookup until the output register can take the result
        done = !rsp_valid_q || rsp_o.ready;
        if (done) begin
          state_d = sacl_pkg::S_IDLE;
        end
      end
      default: state_d = sacl_pkg::S_IDLE;
    endcase
  end

  assign req_xfer = req_i.valid && req_i.ready;

  assign rd_o.en  = req_xfer;
  assign rd_o.set = req_i.address[sacl_pkg::OFFSET_W +: sacl_pkg::SET_W];

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_type_q <= req_i.req_type;
      tag_q      <= req_i.address[sacl_pkg::ADDR_W-1:sacl_pkg::OFFSET_W];
    end
  end

  // Tag compare, victim choice and new line state
  always_comb begin
    match     = '0;
    oldest    = '0;
    hit_way   = '0;
    empty_way = '0;
    old_way   = '0;
    for (int w = 0; w < sacl_pkg::WAYS; w++) begin
      match[w]  = meta_row_i.valid[w] && (tag_row_i[w] == tag_q);
      oldest[w] = (meta_row_i.rank[w] == sacl_pkg::RANK_MAX);
    end
    for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = sacl_pkg::WAY_W'(w);
      end
      if (!meta_row_i.valid[w]) begin
        empty_way = sacl_pkg::WAY_W'(w);
      end
      if (oldest[w]) begin
        old_way = sacl_pkg::WAY_W'(w);
      end
    end
    hit     = |match;
    full    = &meta_row_i.valid;
    sel_way = hit ? hit_way : (full ? old_way : empty_way);
    dev     = !hit && full && meta_row_i.dirty[sel_way];
    mwrite  = cfg_i.write_back_mode ? dev : req_type_q;

    meta_new = meta_row_i;
    if (hit) begin
      if (req_type_q == sacl_pkg::REQ_WRITE) begin
        meta_new.dirty[sel_way] = 1'b1;
      end
      if (cfg_i.replacement_mode == sacl_pkg::REPL_LRU) begin
        for (int w = 0; w < sacl_pkg::WAYS; w++) begin
          if (sacl_pkg::WAY_W'(w) != sel_way && meta_row_i.valid[w] &&
              meta_row_i.rank[w] < meta_row_i.rank[sel_way]) begin
            meta_new.rank[w] = meta_row_i.rank[w] + 1'b1;
          end
        end
        meta_new.rank[sel_way] = '0;
      end
    end else begin
      for (int w = 0; w < sacl_pkg::WAYS; w++) begin
        if (sacl_pkg::WAY_W'(w) != sel_way && meta_row_i.valid[w]) begin
          meta_new.rank[w] = meta_row_i.rank[w] + 1'b1;
        end
      end
      meta_new.valid[sel_way] = 1'b1;
      meta_new.dirty[sel_way] = req_type_q;
      meta_new.rank[sel_way]  = '0;
    end
  end

  assign wr_o.en     = done;
  assign wr_o.set    = tag_q[sacl_pkg::SET_W-1:0];
  assign wr_o.way    = sel_way;
  assign wr_o.tag    = tag_q;
  assign wr_o.tag_en = !hit;
  assign wr_o.meta   = meta_new;

  // Output register
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (done) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      hit_q    <= hit;
      way_q    <= sacl_pkg::OUT_WAY_W'(sel_way);
      mread_q  <= !hit;
      mwrite_q <= mwrite;
      dev_q    <= dev;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.hit            = hit_q;
  assign rsp_o.way            = way_q;
  assign rsp_o.memory_read    = mread_q;
  assign rsp_o.memory_write   = mwrite_q;
  assign rsp_o.dirty_eviction = dev_q;

  // A full set always has exactly one way at the top rank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sacl_pkg::S_LOOK && full) |-> $onehot(oldest))
    else $error("full set without a unique oldest way");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.hit != rsp_o.memory_read))
    else $error("hit and memory read disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.dirty_eviction) |-> (!rsp_o.hit && rsp_o.memory_read))
    else $error("dirty eviction reported on a hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (rsp_o.valid && state_q == sacl_pkg::S_IDLE))
    else $error("completed lookup did not reach the output register");

endmodule

// ===== rtl/set_assoc_cache_lru_fifo_core.sv =====
`timescale 1ns / 1ps
// Set-associative cache tag controller, LRU or FIFO replacement, write-through or
// write-back memory write reporting.
//
// Channels: req_i carries one access (req_type 0 read, 1 write, 64-bit byte address);
// rsp_o returns one result per access: hit, way, memory_read, memory_write and
// dirty_eviction. Both are valid/ready, a transfer happens when both are high.
// Configuration: APB registers at 0x0 (replacement_mode) and 0x4 (write_back_mode);
// the user must write them only while no access is outstanding, which the block itself
// does not enforce. pready is tied high.
// Flow: the transfer of an access starts the registered read of the set memories;
// in the lookup state the result is loaded into the output register as soon as that
// register is free, and the updated set is written back at the same time. One access
// is in flight at a time: the next is taken only once the lookup has completed.
// Reset clears the line state at once through per-set written flags; tags are undefined
// until filled, and there is no clearing pass.
// A stalled receiver holds the result; the next access may still be taken and waits
// at the lookup stage until the output register frees.
module set_assoc_cache_lru_fifo_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  sacl_req_if.sink     req_i,
  sacl_rsp_if.source   rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  sacl_pkg::cfg_t      cfg;
  logic                replacement_mode_q;
  logic                write_back_mode_q;
  logic                reg_sel;
  sacl_pkg::rd_t       rd;
  sacl_pkg::wr_t       wr;
  sacl_pkg::tag_row_t  tag_row;
  sacl_pkg::meta_row_t meta_row;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replacement_mode_q <= 1'b0;
      write_back_mode_q  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        sacl_pkg::REG_REPLACEMENT: replacement_mode_q <= pwdata[0];
        sacl_pkg::REG_WRITE_BACK:  write_back_mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      sacl_pkg::REG_REPLACEMENT: prdata[0] = replacement_mode_q;
      sacl_pkg::REG_WRITE_BACK:  prdata[0] = write_back_mode_q;
      default: prdata = '0;
    endcase
  end

  assign cfg.replacement_mode = replacement_mode_q;
  assign cfg.write_back_mode  = write_back_mode_q;

  sacl_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (tag_row)
  );

  sacl_meta_ram u_meta_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (meta_row)
  );

  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .cfg_i      (cfg),
    .tag_row_i  (tag_row),
    .meta_row_i (meta_row),
    .rd_o       (rd),
    .wr_o       (wr)
  );

endmodule
